FILE: rtl/core/amr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg: shared types and constants
// Widths, fixed-point constants, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package amr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = 11;   // counts, positions, set size
    localparam int RANK_W      = 27;   // adjusted rank, Q11.16
    localparam int MED_W       = 16;   // median rank, Q0.16
    localparam int NUM_W       = 31;   // 10 * adjusted rank
    localparam int DVD_W       = 38;   // divider dividend and quotient
    localparam int DVS_W       = 14;   // divider divisor (10*N + 4 <= 10244)
    localparam int STEP_W      = 6;    // divider step counter
    localparam int IN_W        = 8;    // s_tdata width
    localparam int OUT_W       = 56;   // m_tdata width

    localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_SAMPLES);
    localparam logic [NUM_W-1:0]  THREE_ONE = NUM_W'(3) << FRAC_BITS;
    localparam logic [RANK_W-1:0] RANK_MAX  = {RANK_W{1'b1}};
    localparam logic [MED_W-1:0]  MED_MAX   = {MED_W{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV1_LOAD,
        ST_DIV1_RUN,
        ST_ADJ,
        ST_DIV2_LOAD,
        ST_DIV2_RUN,
        ST_OUT
    } amr_state_t;

    typedef struct packed {
        logic ready;      // controller can take an item
        logic mul;        // form reverse rank times previous rank
        logic div1_load;  // start the adjusted-rank division
        logic adj_load;   // capture the saturated adjusted rank
        logic div2_load;  // start the median-rank division
        logic commit;     // write the result item and the set state
    } amr_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_failure;
        logic div_done;
        logic out_free;
    } amr_sts_t;

endpackage

FILE: rtl/core/amr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_div: serial restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step
// and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module amr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [amr_pkg::DVD_W-1:0]   dividend,
    input  logic [amr_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [amr_pkg::DVD_W-1:0]   quotient
);
    import amr_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVD_W-1:0]    acc_reg, acc_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, acc_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where it fits
            rem_next  = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            acc_next  = {acc_reg[DVD_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= LAST_STEP)
        else $error("divider step count out of range");

endmodule

FILE: rtl/core/amr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_dp: rank datapath
// Set-size register, set state, multiplier, shared divider and the output
// register.
// ----------------------------------------------------------------------------
module amr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [amr_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic [amr_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [amr_pkg::OUT_W-1:0]   m_tdata,
    input  amr_pkg::amr_cmd_t           cmd,
    output amr_pkg::amr_sts_t           sts
);
    import amr_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [CNT_W-1:0]  fails_reg, fails_next;

    logic [CNT_W-1:0]  r_reg;
    logic [RANK_W-1:0] prev_reg;
    logic [CNT_W-1:0]  fnum_reg;
    logic              end_reg;
    logic [DVD_W-1:0]  prod_reg;
    logic [RANK_W-1:0] adj_reg;

    logic              m_valid_reg, m_valid_next;
    logic [MED_W-1:0]  m_med_reg;
    logic [RANK_W-1:0] m_adj_reg;
    logic [CNT_W-1:0]  m_fnum_reg;

    logic [CNT_W-1:0]  n;
    logic              stale;
    logic [CNT_W-1:0]  pos_eff;
    logic [RANK_W-1:0] rank_eff;
    logic [CNT_W-1:0]  fails_eff;
    logic [CNT_W-1:0]  pos_inc;
    logic              set_end;
    logic              accept;
    logic              failure;

    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  quot;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  num_adj;
    logic [RANK_W-1:0] adj_sat;
    logic [MED_W-1:0]  med_sat;

    // effective set size: zero reads as one, large values clamp
    always_comb begin
        if (count_reg == '0) begin
            n = CNT_W'(1);
        end else if (count_reg > MAX_N) begin
            n = MAX_N;
        end else begin
            n = count_reg;
        end
    end

    assign stale     = pos_reg >= n;
    assign pos_eff   = stale ? '0 : pos_reg;
    assign rank_eff  = stale ? '0 : rank_reg;
    assign fails_eff = stale ? '0 : fails_reg;
    assign pos_inc   = pos_eff + CNT_W'(1);
    assign set_end   = pos_inc >= n;
    assign accept    = cmd.ready && s_tvalid;
    assign failure   = s_tdata[0];

    // set state; a failure's operands are captured at accept, so the last
    // record of a set clears the state right away
    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        rank_next  = rank_reg;
        fails_next = fails_reg;
        if (cfg_wr_en) begin
            count_next = cfg_wr_data;
            pos_next   = '0;
            rank_next  = '0;
            fails_next = '0;
        end else if (accept) begin
            pos_next = set_end ? '0 : pos_inc;
            if (set_end) begin
                rank_next  = '0;
                fails_next = '0;
            end else if (!failure) begin
                rank_next  = rank_eff;
                fails_next = fails_eff;
            end
        end else if (cmd.commit) begin
            rank_next  = end_reg ? '0 : adj_reg;
            fails_next = end_reg ? '0 : fnum_reg;
        end
    end

    // divider operands
    assign num     = (NUM_W'(adj_reg) << 3) + (NUM_W'(adj_reg) << 1);
    assign num_adj = (num > THREE_ONE) ? (num - THREE_ONE) : '0;

    always_comb begin
        div_start = cmd.div1_load || cmd.div2_load;
        if (cmd.div1_load) begin
            div_dvd = prod_reg + (DVD_W'(n + CNT_W'(1)) << FRAC_BITS);
            div_dvs = DVS_W'(r_reg) + DVS_W'(1);
        end else begin
            div_dvd = DVD_W'(num_adj);
            div_dvs = (DVS_W'(n) << 3) + (DVS_W'(n) << 1) + DVS_W'(4);
        end
    end

    amr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quot)
    );

    assign adj_sat = (quot[DVD_W-1:RANK_W] != '0) ? RANK_MAX : quot[RANK_W-1:0];
    assign med_sat = (quot[DVD_W-1:MED_W] != '0) ? MED_MAX : quot[MED_W-1:0];

    // output register
    assign sts.out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CNT_W'(1);
            pos_reg     <= '0;
            rank_reg    <= '0;
            fails_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            rank_reg    <= rank_next;
            fails_reg   <= fails_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            r_reg    <= n - pos_eff;
            prev_reg <= rank_eff;
            fnum_reg <= fails_eff + CNT_W'(1);
            end_reg  <= set_end;
        end
        if (cmd.mul) begin
            prod_reg <= DVD_W'(r_reg) * DVD_W'(prev_reg);
        end
        if (cmd.adj_load) begin
            adj_reg <= adj_sat;
        end
        if (cmd.commit) begin
            m_med_reg  <= med_sat;
            m_adj_reg  <= adj_reg;
            m_fnum_reg <= fnum_reg;
        end
    end

    assign sts.in_valid   = s_tvalid;
    assign sts.in_failure = failure;
    assign sts.div_done   = div_done;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - MED_W - RANK_W - CNT_W){1'b0}},
                       m_fnum_reg, m_adj_reg, m_med_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("result item overwritten before it was taken");

    a_pos_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < n)
        else $error("position outside the current set");

    a_fails_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        fails_reg <= pos_reg)
        else $error("more failures than records in the set");

endmodule

FILE: rtl/core/amr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_ctrl: sequencing state machine
// Steps a failure through multiply, two divisions and the output handoff.
// ----------------------------------------------------------------------------
module amr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  amr_pkg::amr_sts_t   sts,
    output amr_pkg::amr_cmd_t   cmd
);
    import amr_pkg::*;

    amr_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sts.in_valid && sts.in_failure) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_DIV1_LOAD;
            ST_DIV1_LOAD: state_next = ST_DIV1_RUN;
            ST_DIV1_RUN: begin
                if (sts.div_done) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:       state_next = ST_DIV2_LOAD;
            ST_DIV2_LOAD: state_next = ST_DIV2_RUN;
            ST_DIV2_RUN: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:      cmd.ready     = 1'b1;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_DIV1_LOAD: cmd.div1_load = 1'b1;
            ST_ADJ:       cmd.adj_load  = 1'b1;
            ST_DIV2_LOAD: cmd.div2_load = 1'b1;
            ST_OUT:       cmd.commit    = sts.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/adjusted_median_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjusted_median_rank: Johnson adjusted rank and Bernard median rank
// Takes ordered life-test records (failure or suspension), one item each, and
// returns one result item per failure.
// ----------------------------------------------------------------------------
// Usage: write the set size N to cfg_wr_data with cfg_wr_en while the block is
// idle; the write starts a new set. N = 0 is taken as 1 and N above 1024 as
// 1024. Each input item carries is_failure in s_tdata[0]. A suspension is
// taken while the block stays idle and gives no result. A failure goes
// through a multiply, then two passes through a single serial restoring
// divider (adjusted rank, then median rank) that gives one quotient bit per
// cycle; no further item is taken until its result is in the output register.
// A finished result waits in the output register while the next item is taken.
// Results are truncated: adjusted rank in Q11.16 saturating at all ones,
// median rank in Q0.16 clamped to zero below 0.3 and saturating at all ones.
// After N records the set state clears on its own.
// ----------------------------------------------------------------------------
module adjusted_median_rank (
    input  logic                        aclk,
    input  logic                        aresetn,
    // set-size register
    input  logic                        cfg_wr_en,
    input  logic [amr_pkg::CNT_W-1:0]   cfg_wr_data,   // sample_count
    // record items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [amr_pkg::IN_W-1:0]    s_tdata,       // [0] is_failure, [7:1] zero
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [amr_pkg::OUT_W-1:0]   m_tdata        // [15:0] bernard_rank,
                                                       // [42:16] adjusted_rank,
                                                       // [53:43] failure_number,
                                                       // [55:54] zero
);
    import amr_pkg::*;

    amr_cmd_t cmd;
    amr_sts_t sts;

    // sequence a failure through multiply, divide, divide, hand off
    amr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold set state, do the arithmetic, drive the result register
    amr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

    // take an item only while the sequencer is idle
    assign s_tready = cmd.ready;

endmodule
